// ===== sv/rrb_pkg.sv =====
// Shared types and constants for the Ridder bracket sequencer.
// No dependencies.
package rrb_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned PROD_W = 63;          // product magnitudes stay within 2^62
  localparam int unsigned CNT_W  = 6;

  localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(32);  // 33 multiplier bits
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(31);  // 32 root digits
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(62);  // 63 quotient bits

  localparam logic [PROD_W-1:0] PROD_LIMIT = {1'b1, {(PROD_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_QUERY = 2'd0,
    KIND_WIDTH = 2'd1,
    KIND_VALUE = 2'd2,
    KIND_LIMIT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_MID  = 2'd1,
    PH_CAND = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    S_IN,
    S_CHECK,
    S_MUL,
    S_DISC,
    S_SQRT,
    S_DIV,
    S_CAND,
    S_UPD
  } state_t;

  typedef enum logic [1:0] {
    MUL_FM2 = 2'd0,
    MUL_FAFB = 2'd1,
    MUL_NUM = 2'd2
  } mul_sel_t;

  localparam logic CFG_TOL  = 1'b0;
  localparam logic CFG_ITER = 1'b1;

  // input item function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_VALUE = 1'b1;

  function automatic logic [VAL_W-1:0] mag32(input logic signed [VAL_W-1:0] x);
    logic [VAL_W-1:0] r;
    r = x[VAL_W-1] ? VAL_W'(-x) : VAL_W'(x);
    return r;
  endfunction

endpackage

// ===== sv/rrb_in_if.sv =====
// Input channel of the Ridder sequencer: valid/ready plus one item.
// Depends on nothing.
interface rrb_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] point_low;
  logic signed [31:0] point_high;
  logic signed [31:0] value_low;
  logic signed [31:0] value_high;
  logic signed [31:0] sample_value;

  modport source (output valid, func, point_low, point_high, value_low, value_high,
                  sample_value, input ready);
  modport sink (input valid, func, point_low, point_high, value_low, value_high,
                sample_value, output ready);
endinterface

// ===== sv/rrb_out_if.sv =====
// Result channel of the Ridder sequencer: valid/ready plus one result.
// Depends on nothing.
interface rrb_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] point;
  logic [31:0]        error;
  logic [15:0]        iterations;

  modport source (output valid, kind, point, error, iterations, input ready);
  modport sink (input valid, kind, point, error, iterations, output ready);
endinterface

// ===== sv/ridder_root_bracket_step.sv =====
// Ridder root-finding sequencer, top level.
// Depends on rrb_pkg, rrb_in_if and rrb_out_if.
//
// Usage: in_ch carries one beat per item. func 0 loads a bracket and the
// function values at its ends and always restarts; func 1 delivers f at the
// last point asked for (ignored when no point is outstanding). out_ch gives
// one beat per answered item: a query point or a final result.
// cfg_we/cfg_index/cfg_data write tolerance (index 0) or the iteration limit
// (index 1); write only while idle.
// Work per item, up to the load of the result (out_ch free): a start goes
// through S_CHECK; f(midpoint) runs three bit-serial products over 33
// multiplier bits, a 32-digit square root and a 63-bit restoring divide one
// after another, the products on shared multiplier shift registers, and the
// divide is skipped when the root is zero; f(candidate) is answered from
// S_UPD when it converges on value, else via S_CHECK. One item is in work at
// a time; in_ch.ready is high only while waiting for an item.
// A finished result sits in the output register, and the next beat is taken
// meanwhile; the sequencer holds a new result until out_ch drains, so a
// receiver stall holds the sequencer up.
// Reset (rst, synchronous): bracket state cleared, no point outstanding,
// tolerance 1, iteration limit 1000.
module ridder_root_bracket_step
  import rrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  rrb_in_if.sink      in_ch,
  rrb_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [30:0] cfg_data
);

  logic [30:0] tolerance;
  logic [15:0] iter_limit;

  logic signed [31:0] bracket_low, bracket_high, fval_low, fval_high;
  logic signed [31:0] mid_point, fval_mid, candidate_point, fval_cand;
  phase_t             phase;
  logic [15:0]        update_count;

  state_t state, state_next;

  // serial datapath registers
  mul_sel_t           mul_sel;
  logic [CNT_W-1:0]   cnt;
  logic [64:0]        mul_md, mul_acc;
  logic [32:0]        mul_mr;
  logic [PROD_W-1:0]  fm2, fafb, num;
  logic [63:0]        sq_rem, sq_res, sq_bit;
  logic [31:0]        root;
  logic [31:0]        dv_rem;
  logic [PROD_W-1:0]  dv_q;
  logic               use_mid;

  logic               o_valid;
  kind_t              o_kind;
  logic signed [31:0] o_point;
  logic [31:0]        o_error;
  logic [15:0]        o_iter;

  logic o_free;
  assign o_free = !o_valid || out_ch.ready;

  assign in_ch.ready       = (state == S_IN);
  assign out_ch.valid      = o_valid;
  assign out_ch.kind       = o_kind;
  assign out_ch.point      = o_point;
  assign out_ch.error      = o_error;
  assign out_ch.iterations = o_iter;

  // check round
  logic signed [32:0] chk_sum, chk_diff;
  logic signed [31:0] chk_mid;
  logic [31:0]        chk_width;
  assign chk_sum   = 33'(bracket_low) + 33'(bracket_high);
  assign chk_mid   = chk_sum[32:1];
  assign chk_diff  = 33'(bracket_high) - 33'(bracket_low);
  assign chk_width = chk_diff[32] ? 32'(-chk_diff) : chk_diff[31:0];

  // m - a, shared by the numerator and the sign of the step
  logic signed [32:0] m_minus_a;
  logic [32:0]        mag_ma;
  assign m_minus_a = 33'(mid_point) - 33'(bracket_low);
  assign mag_ma    = m_minus_a[32] ? 33'(-m_minus_a) : 33'(m_minus_a);

  // multiplier step
  logic [64:0] acc_step;
  assign acc_step = mul_mr[0] ? mul_acc + mul_md : mul_acc;

  // operands for each product
  logic [32:0] op_x;
  logic [31:0] op_y;
  mul_sel_t    sel_load;
  always_comb begin
    unique case (sel_load)
      MUL_FM2:  begin op_x = {1'b0, mag32(fval_mid)};  op_y = mag32(fval_mid); end
      MUL_FAFB: begin op_x = {1'b0, mag32(fval_low)};  op_y = mag32(fval_high); end
      MUL_NUM:  begin op_x = mag_ma;                   op_y = mag32(fval_mid); end
      default:  begin op_x = '0;                       op_y = '0; end
    endcase
  end

  // discriminant
  logic [63:0] disc;
  always_comb begin
    if (fafb != '0 && (fval_low[31] != fval_high[31]))
      disc = 64'(fm2) + 64'(fafb);
    else if (fm2 > fafb)
      disc = 64'(fm2 - fafb);
    else
      disc = '0;
  end

  // root digit
  logic [63:0] sq_trial;
  logic        sq_take;
  assign sq_trial = sq_res + sq_bit;
  assign sq_take  = sq_rem >= sq_trial;

  // divide step
  logic [32:0] dv_part;
  logic        dv_take;
  assign dv_part = {dv_rem, dv_q[PROD_W-1]};
  assign dv_take = dv_part >= {1'b0, root};

  // candidate point
  logic signed [32:0] fa_minus_fb;
  logic               step_neg;
  logic signed [33:0] cand_raw;
  logic signed [31:0] cand_pt;
  assign fa_minus_fb = 33'(fval_low) - 33'(fval_high);
  assign step_neg    = fa_minus_fb[32] ^ m_minus_a[32] ^ fval_mid[31];
  always_comb begin
    cand_raw = step_neg ? 34'(mid_point) - 34'(dv_q[30:0])
                        : 34'(mid_point) + 34'(dv_q[30:0]);
    if (use_mid || cand_raw <= 34'(bracket_low) || cand_raw >= 34'(bracket_high))
      cand_pt = mid_point;
    else
      cand_pt = cand_raw[31:0];
  end

  logic [31:0] mag_fc;
  assign mag_fc = mag32(fval_cand);

  logic o_load;
  assign o_load = o_free && (state == S_CHECK || state == S_CAND ||
                  (state == S_UPD && {1'b0, mag_fc} < {2'b0, tolerance}));

  always_comb begin
    state_next = state;
    sel_load   = MUL_FM2;
    unique case (state)
      S_IN: begin
        if (in_ch.valid) begin
          if (in_ch.func == FUNC_START)  state_next = S_CHECK;
          else if (phase == PH_MID)      state_next = S_MUL;
          else if (phase == PH_CAND)     state_next = S_UPD;
        end
      end
      S_CHECK: if (o_free) state_next = S_IN;
      S_MUL: begin
        sel_load = (mul_sel == MUL_FM2) ? MUL_FAFB : MUL_NUM;
        if (cnt == MUL_LAST && mul_sel == MUL_NUM) state_next = S_DISC;
      end
      S_DISC: state_next = S_SQRT;
      S_SQRT: begin
        if (cnt == SQRT_LAST) begin
          if (sq_take ? ((sq_res >> 1) + sq_bit) == '0 : (sq_res >> 1) == '0)
            state_next = S_CAND;
          else
            state_next = S_DIV;
        end
      end
      S_DIV:  if (cnt == DIV_LAST) state_next = S_CAND;
      S_CAND: if (o_free) state_next = S_IN;
      S_UPD: begin
        if ({1'b0, mag_fc} < {2'b0, tolerance}) begin
          if (o_free) state_next = S_IN;
        end else begin
          state_next = S_CHECK;
        end
      end
      default: state_next = S_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IN;
    else     state <= state_next;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance  <= 31'd1;
      iter_limit <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOL:  tolerance  <= cfg_data;
        CFG_ITER: iter_limit <= cfg_data[15:0];
        default:  ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_load) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free) begin
      unique case (state)
        S_CHECK: begin
          o_point <= chk_mid;
          o_iter  <= update_count;
          if (update_count >= iter_limit) begin
            o_kind  <= KIND_LIMIT;
            o_error <= chk_width;
          end else if ({1'b0, chk_width} < {2'b0, tolerance}) begin
            o_kind  <= KIND_WIDTH;
            o_error <= chk_width;
          end else begin
            o_kind  <= KIND_QUERY;
            o_error <= '0;
          end
        end
        S_CAND: begin
          o_kind  <= KIND_QUERY;
          o_point <= cand_pt;
          o_error <= '0;
          o_iter  <= update_count;
        end
        S_UPD: begin
          o_kind  <= KIND_VALUE;
          o_point <= candidate_point;
          o_error <= mag_fc;
          o_iter  <= update_count;
        end
        default: ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      bracket_low     <= '0;
      bracket_high    <= '0;
      fval_low        <= '0;
      fval_high       <= '0;
      mid_point       <= '0;
      fval_mid        <= '0;
      candidate_point <= '0;
      fval_cand       <= '0;
      phase           <= PH_IDLE;
      update_count    <= '0;
    end else begin
      unique case (state)
        S_IN: begin
          if (in_ch.valid) begin
            if (in_ch.func == FUNC_START) begin
              bracket_low  <= in_ch.point_low;
              bracket_high <= in_ch.point_high;
              fval_low     <= in_ch.value_low;
              fval_high    <= in_ch.value_high;
              update_count <= '0;
            end else if (phase == PH_MID) begin
              fval_mid <= in_ch.sample_value;
            end else if (phase == PH_CAND) begin
              fval_cand <= in_ch.sample_value;
            end
          end
        end
        S_CHECK: begin
          if (o_free) begin
            if (update_count >= iter_limit ||
                {1'b0, chk_width} < {2'b0, tolerance}) begin
              phase <= PH_IDLE;
            end else begin
              phase     <= PH_MID;
              mid_point <= chk_mid;
            end
          end
        end
        S_CAND: begin
          if (o_free) begin
            candidate_point <= cand_pt;
            phase           <= PH_CAND;
          end
        end
        S_UPD: begin
          if ({1'b0, mag_fc} < {2'b0, tolerance}) begin
            if (o_free) phase <= PH_IDLE;
          end else begin
            if (fval_low != '0 && fval_cand != '0 && (fval_low[31] != fval_cand[31])) begin
              bracket_high <= candidate_point;
              fval_high    <= fval_cand;
            end else if (fval_mid != '0 && fval_cand != '0 &&
                         (fval_mid[31] != fval_cand[31])) begin
              if (candidate_point < mid_point) begin
                bracket_high <= mid_point;
                fval_high    <= fval_mid;
              end else begin
                bracket_low <= mid_point;
                fval_low    <= fval_mid;
              end
            end else begin
              bracket_low <= candidate_point;
              fval_low    <= fval_cand;
            end
            update_count <= update_count + 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // serial datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      mul_sel <= MUL_FM2;
      use_mid <= 1'b0;
    end else begin
      unique case (state)
        S_IN: begin
          // f(mid) is squared first, taken straight from the incoming beat
          cnt     <= '0;
          mul_sel <= MUL_FM2;
          mul_acc <= '0;
          mul_md  <= 65'(mag32(in_ch.sample_value));
          mul_mr  <= {1'b0, mag32(in_ch.sample_value)};
        end
        S_MUL: begin
          if (cnt == MUL_LAST) begin
            unique case (mul_sel)
              MUL_FM2:  fm2  <= acc_step[PROD_W-1:0];
              MUL_FAFB: fafb <= acc_step[PROD_W-1:0];
              MUL_NUM:  num  <= (acc_step > 65'(PROD_LIMIT)) ? PROD_LIMIT
                                                             : acc_step[PROD_W-1:0];
              default:  ;
            endcase
            cnt     <= '0;
            mul_sel <= sel_load;
            mul_acc <= '0;
            mul_md  <= 65'(op_y);
            mul_mr  <= op_x;
          end else begin
            cnt     <= cnt + 1'b1;
            mul_acc <= acc_step;
            mul_md  <= {mul_md[63:0], 1'b0};
            mul_mr  <= {1'b0, mul_mr[32:1]};
          end
        end
        S_DISC: begin
          sq_rem <= disc;
          sq_res <= '0;
          sq_bit <= 64'h4000_0000_0000_0000;
          cnt    <= '0;
        end
        S_SQRT: begin
          if (sq_take) begin
            sq_rem <= sq_rem - sq_trial;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (cnt == SQRT_LAST) begin
            root    <= sq_take ? 32'((sq_res >> 1) + sq_bit) : 32'(sq_res >> 1);
            use_mid <= 1'b1;
            cnt     <= '0;
            dv_rem  <= '0;
            dv_q    <= num;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DIV: begin
          dv_rem <= dv_take ? 32'(dv_part - {1'b0, root}) : dv_part[31:0];
          dv_q   <= {dv_q[PROD_W-2:0], dv_take};
          if (cnt == DIV_LAST) begin
            // quotient above the value range falls back to the midpoint
            use_mid <= ({dv_q[PROD_W-2:0], dv_take} >> 31) != '0;
            cnt     <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
